### hdl/rrdc_pkg.sv
package rrdc_pkg;

	// Parameter defaults
	localparam int CACHE_ENTRIES_DEF = 8;
	localparam int RESULT_BYTES_DEF  = 1024;

	// Field widths
	localparam int ID_W       = 32;
	localparam int HWM_W      = 31;
	localparam int DIG_W      = 32;
	localparam int TS_W       = 4;
	localparam int LEN_W      = 16;
	localparam int BST_W      = 3;
	localparam int SLOT_OUT_W = 8;

	typedef enum logic [BST_W-1:0] {
		BST_OK        = 3'd0,
		BST_BAD_ID    = 3'd1,
		BST_EXPIRED   = 3'd2,
		BST_CONFLICT  = 3'd3,
		BST_NO_TOOL   = 3'd4,
		BST_TOO_LARGE = 3'd5
	} blk_status_t;

	typedef enum logic {
		OP_CALL  = 1'b0,
		OP_RESET = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		RES_BAD_ID,
		RES_EXPIRED,
		RES_LOOKUP,
		RES_FRESH
	} res_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN
	} ctrl_state_t;

	// One ring entry
	typedef struct packed {
		logic [HWM_W-1:0] id;
		logic [DIG_W-1:0] dig;
		blk_status_t      bst;
		logic [TS_W-1:0]  ts;
		logic [LEN_W-1:0] len;
	} entry_t;

	// Controller -> datapath
	typedef struct packed {
		logic     capture;
		logic     clear;
		logic     fresh_write;
		logic     scan_start;
		logic     scan_step;
		logic     load;
		res_sel_t sel;
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic is_reset;
		logic bad_id;
		logic fresh;
		logic hit;
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

### hdl/rrdc_req_if.sv
interface rrdc_req_if import rrdc_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic signed [ID_W-1:0]  call_id;
	logic [DIG_W-1:0]        arg_hash;
	logic                    tool_found;
	logic [TS_W-1:0]         tool_status;
	logic [LEN_W-1:0]        produced_length;

	modport source (
		output valid, operation, call_id, arg_hash, tool_found, tool_status,
			produced_length,
		input  ready
	);

	modport sink (
		input  valid, operation, call_id, arg_hash, tool_found, tool_status,
			produced_length,
		output ready
	);
endinterface

### hdl/rrdc_rsp_if.sv
interface rrdc_rsp_if import rrdc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [BST_W-1:0]      block_status;
	logic [TS_W-1:0]       echo_tool_status;
	logic                  from_cache;
	logic [LEN_W-1:0]      stored_length;
	logic [SLOT_OUT_W-1:0] entry_slot;

	modport source (
		output valid, block_status, echo_tool_status, from_cache, stored_length, entry_slot,
		input  ready
	);

	modport sink (
		input  valid, block_status, echo_tool_status, from_cache, stored_length, entry_slot,
		output ready
	);
endinterface

### hdl/rrdc_ctrl.sv
module rrdc_ctrl import rrdc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.sel  = RES_BAD_ID;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.is_reset) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end else if (sts.bad_id) begin
					if (sts.out_free) begin
						cmd.load = 1'b1;
						cmd.sel  = RES_BAD_ID;
						state_d  = ST_IDLE;
					end
				end else if (sts.fresh) begin
					if (sts.out_free) begin
						cmd.fresh_write = 1'b1;
						cmd.load        = 1'b1;
						cmd.sel         = RES_FRESH;
						state_d         = ST_IDLE;
					end
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// a hit or a finished miss holds the read stage until the output frees
				if (sts.hit) begin
					if (sts.out_free) begin
						cmd.load = 1'b1;
						cmd.sel  = RES_LOOKUP;
						state_d  = ST_IDLE;
					end
				end else if (sts.scan_done) begin
					if (sts.out_free) begin
						cmd.load = 1'b1;
						cmd.sel  = RES_EXPIRED;
						state_d  = ST_IDLE;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/rrdc_dpath.sv
module rrdc_dpath import rrdc_pkg::*; #(
	parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
	parameter int RESULT_BYTES  = RESULT_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_sts_t                sts,
	input  logic                   operation,
	input  logic signed [ID_W-1:0] call_id,
	input  logic [DIG_W-1:0]       arg_hash,
	input  logic                   tool_found,
	input  logic [TS_W-1:0]        tool_status,
	input  logic [LEN_W-1:0]       produced_length,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [BST_W-1:0]       block_status,
	output logic [TS_W-1:0]        echo_tool_status,
	output logic                   from_cache,
	output logic [LEN_W-1:0]       stored_length,
	output logic [SLOT_OUT_W-1:0]  entry_slot
);

	localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
	localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(CACHE_ENTRIES);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CACHE_ENTRIES - 1);
	localparam logic [LEN_W-1:0]  LEN_LIMIT = LEN_W'(RESULT_BYTES);

	// captured request
	op_t                    op_q;
	logic signed [ID_W-1:0] rid_q;
	logic [DIG_W-1:0]       dig_q;
	logic                   found_q;
	logic [TS_W-1:0]        ts_q;
	logic [LEN_W-1:0]       plen_q;

	// table state
	logic [HWM_W-1:0]         hwm_q;
	logic [SLOT_W-1:0]        next_slot_q;
	logic [CACHE_ENTRIES-1:0] valid_q;
	entry_t                   slot_mem_q [CACHE_ENTRIES];

	// scan read stage
	logic [CNT_W-1:0]  scan_idx_q;
	logic [SLOT_W-1:0] rd_idx;
	logic              rd_issue;
	logic              pend_s1;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	entry_t            rd_s1;

	// result register
	logic              out_valid_q;
	blk_status_t       out_bst_q;
	logic [TS_W-1:0]   out_ts_q;
	logic              out_cache_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [SLOT_W-1:0] out_slot_q;

	entry_t            fresh_entry;
	blk_status_t       fresh_bst;
	blk_status_t       res_bst;
	logic [TS_W-1:0]   res_ts;
	logic              res_cache;
	logic [LEN_W-1:0]  res_len;
	logic [SLOT_W-1:0] res_slot;

	assign rd_idx   = scan_idx_q[SLOT_W-1:0];
	assign rd_issue = cmd.scan_step && (scan_idx_q != CNT_END);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(operation);
			rid_q   <= call_id;
			dig_q   <= arg_hash;
			found_q <= tool_found;
			ts_q    <= tool_status;
			plen_q  <= produced_length;
		end
	end

	// fresh outcome
	always_comb begin
		if (!found_q) begin
			fresh_bst = BST_NO_TOOL;
		end else if (plen_q > LEN_LIMIT) begin
			fresh_bst = BST_TOO_LARGE;
		end else begin
			fresh_bst = BST_OK;
		end
		fresh_entry.id  = rid_q[HWM_W-1:0];
		fresh_entry.dig = dig_q;
		fresh_entry.bst = fresh_bst;
		fresh_entry.ts  = (fresh_bst == BST_OK) ? ts_q : '0;
		fresh_entry.len = (fresh_bst == BST_OK) ? plen_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_q       <= '0;
			next_slot_q <= '0;
			valid_q     <= '0;
		end else if (cmd.clear) begin
			hwm_q       <= '0;
			next_slot_q <= '0;
			valid_q     <= '0;
		end else if (cmd.fresh_write) begin
			hwm_q                <= rid_q[HWM_W-1:0];
			next_slot_q          <= (next_slot_q == SLOT_LAST) ? '0 : next_slot_q + 1'b1;
			valid_q[next_slot_q] <= 1'b1;
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.fresh_write) begin
			slot_mem_q[next_slot_q] <= fresh_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_s1  <= slot_mem_q[rd_idx];
			vld_s1 <= valid_q[rd_idx];
			idx_s1 <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			pend_s1    <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_idx_q <= '0;
			pend_s1    <= 1'b0;
		end else if (cmd.scan_step) begin
			pend_s1 <= rd_issue;
			if (rd_issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	assign sts.is_reset  = (op_q == OP_RESET);
	assign sts.bad_id    = rid_q[ID_W-1] || (rid_q == '0);
	assign sts.fresh     = rid_q[HWM_W-1:0] > hwm_q;
	assign sts.hit       = pend_s1 && vld_s1 && (rd_s1.id == rid_q[HWM_W-1:0]);
	assign sts.scan_done = !pend_s1 && (scan_idx_q == CNT_END);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		res_bst   = BST_BAD_ID;
		res_ts    = '0;
		res_cache = 1'b0;
		res_len   = '0;
		res_slot  = '0;
		case (cmd.sel)
			RES_BAD_ID: begin
				res_bst = BST_BAD_ID;
			end
			RES_EXPIRED: begin
				res_bst = BST_EXPIRED;
			end
			RES_LOOKUP: begin
				if (rd_s1.dig != dig_q) begin
					res_bst = BST_CONFLICT;
				end else begin
					res_bst   = rd_s1.bst;
					res_ts    = (rd_s1.bst == BST_OK) ? rd_s1.ts : '0;
					res_cache = 1'b1;
					res_len   = rd_s1.len;
					res_slot  = idx_s1;
				end
			end
			RES_FRESH: begin
				res_bst  = fresh_entry.bst;
				res_ts   = fresh_entry.ts;
				res_len  = fresh_entry.len;
				res_slot = next_slot_q;
			end
			default: begin
				res_bst = BST_BAD_ID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_bst_q   <= res_bst;
			out_ts_q    <= res_ts;
			out_cache_q <= res_cache;
			out_len_q   <= res_len;
			out_slot_q  <= res_slot;
		end
	end

	assign out_valid        = out_valid_q;
	assign block_status     = out_bst_q;
	assign echo_tool_status = out_ts_q;
	assign from_cache       = out_cache_q;
	assign stored_length    = out_len_q;
	assign entry_slot       = SLOT_OUT_W'(out_slot_q);

endmodule

### hdl/request_replay_dedup_cache_top.sv
// Channel  Dir  Modport  Word
// req      in   sink     operation, call_id, arg_hash, tool_found, tool_status,
//                        produced_length
// rsp      out  source   block_status, echo_tool_status, from_cache, stored_length, entry_slot
//
// One word in flight at a time; req.ready is high only while the controller is idle.
// Reset-session and bad-id words are settled in the check state; a new id writes its slot
// and loads its result in the same cycle. A lookup scans the ring from slot 0 upward, so
// a hit in a later slot or a miss takes longer: the ring memory has one registered read port
// and the scan reads one slot per cycle. A full output register stalls the controller only
// while rsp.ready stays low. The result register lets the next word enter while rsp waits.
// arst_n clears the state machine, the mark, the ring pointer and the valid bits;
// no clearing pass over the ring memory is needed.
module request_replay_dedup_cache_top import rrdc_pkg::*; #(
	parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
	parameter int RESULT_BYTES  = RESULT_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rrdc_req_if.sink   req,
	rrdc_rsp_if.source rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing: accept, classify, scan, load result
	rrdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, ring memory, scan read stage and result register
	rrdc_dpath #(
		.CACHE_ENTRIES (CACHE_ENTRIES),
		.RESULT_BYTES  (RESULT_BYTES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.operation        (req.operation),
		.call_id          (req.call_id),
		.arg_hash         (req.arg_hash),
		.tool_found       (req.tool_found),
		.tool_status      (req.tool_status),
		.produced_length  (req.produced_length),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.block_status     (rsp.block_status),
		.echo_tool_status (rsp.echo_tool_status),
		.from_cache       (rsp.from_cache),
		.stored_length    (rsp.stored_length),
		.entry_slot       (rsp.entry_slot)
	);

endmodule

### hdl/rrdc_checker.sv
module rrdc_checker import rrdc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [BST_W-1:0]      block_status,
	input logic [TS_W-1:0]       echo_tool_status,
	input logic                  from_cache,
	input logic [LEN_W-1:0]      stored_length,
	input logic [SLOT_OUT_W-1:0] entry_slot
);

	// a stalled result word stays up
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("rsp valid dropped while stalled");

	a_out_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({block_status, echo_tool_status, from_cache,
			stored_length, entry_slot}))
		else $error("rsp word changed while stalled");

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("req accepted back to back");

	// error results carry no status or length
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (block_status != BST_OK) |-> (echo_tool_status == '0) &&
			(stored_length == '0))
		else $error("error result with nonzero fields");

	// lookup failures point at no entry
	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (block_status == BST_BAD_ID || block_status == BST_EXPIRED ||
			block_status == BST_CONFLICT) |-> !from_cache && (entry_slot == '0))
		else $error("failed lookup names an entry");

endmodule

bind request_replay_dedup_cache_top rrdc_checker u_rrdc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (req.valid),
	.in_ready         (req.ready),
	.out_valid        (rsp.valid),
	.out_ready        (rsp.ready),
	.block_status     (rsp.block_status),
	.echo_tool_status (rsp.echo_tool_status),
	.from_cache       (rsp.from_cache),
	.stored_length    (rsp.stored_length),
	.entry_slot       (rsp.entry_slot)
);

### sim/tb.sv
module tb;
	import rrdc_pkg::*;

	localparam int CE         = CACHE_ENTRIES_DEF;
	localparam int RB         = RESULT_BYTES_DEF;
	localparam int N_WORDS    = 1600;
	localparam int CYCLE_CAP  = 800000;
	localparam int TAIL       = 40;      // quiet time after the last reply, before the verdict
	localparam int LONG_HOLD  = 300;     // receiver hold-off, long enough to back up req
	localparam int MAX_PRINTS = 60;

	// one request word as driven on req
	typedef struct {
		op_t                    op;
		logic signed [ID_W-1:0] id;
		logic [DIG_W-1:0]       dig;
		logic                   found;
		logic [TS_W-1:0]        ts;
		logic [LEN_W-1:0]       len;
	} call_word_t;

	// one response word as seen on rsp
	typedef struct {
		blk_status_t           bst;
		logic [TS_W-1:0]       ts;
		logic                  cached;
		logic [LEN_W-1:0]      len;
		logic [SLOT_OUT_W-1:0] slot;
	} reply_word_t;

	// Shadow of the dedup table plus the queue of replies still owed by the block.
	class dedup_checker;
		logic [HWM_W-1:0] mark;
		int               ring_ptr;
		bit               live    [CE];
		logic [HWM_W-1:0] ent_id  [CE];
		logic [DIG_W-1:0] ent_dig [CE];
		blk_status_t      ent_bst [CE];
		logic [TS_W-1:0]  ent_ts  [CE];
		logic [LEN_W-1:0] ent_len [CE];
		reply_word_t      replies_due[$];
		int               errors;
		int               n_checked;

		function new();
			errors    = 0;
			n_checked = 0;
			clear();
		endfunction

		function void clear();
			mark     = '0;
			ring_ptr = 0;
			foreach (live[s]) live[s] = 1'b0;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("[%0t] reply %0d: %s", $time, n_checked, msg);
		endtask

		function reply_word_t entry_reply(int s, logic cached);
			reply_word_t r;
			r.bst    = ent_bst[s];
			r.ts     = (ent_bst[s] == BST_OK) ? ent_ts[s] : '0;
			r.cached = cached;
			r.len    = ent_len[s];
			r.slot   = SLOT_OUT_W'(s);
			return r;
		endfunction

		// Accepted request word: update the shadow table, queue the owed reply.
		function void note_call(call_word_t w);
			reply_word_t      r;
			logic [HWM_W-1:0] rid;
			int               hit;
			r.bst    = BST_OK;
			r.ts     = '0;
			r.cached = 1'b0;
			r.len    = '0;
			r.slot   = '0;
			if (w.op == OP_RESET) begin
				clear();
				return;
			end
			if ($signed(w.id) <= 0) begin
				r.bst = BST_BAD_ID;
				replies_due.push_back(r);
				return;
			end
			rid = w.id[HWM_W-1:0];
			if (rid <= mark) begin
				// lowest matching slot wins
				hit = -1;
				for (int s = CE - 1; s >= 0; s--)
					if (live[s] && ent_id[s] == rid) hit = s;
				if (hit < 0)
					r.bst = BST_EXPIRED;
				else if (ent_dig[hit] != w.dig)
					r.bst = BST_CONFLICT;
				else
					r = entry_reply(hit, 1'b1);
			end else begin
				mark          = rid;
				hit           = ring_ptr;
				ring_ptr      = (ring_ptr + 1) % CE;
				live[hit]     = 1'b1;
				ent_id[hit]   = rid;
				ent_dig[hit]  = w.dig;
				ent_ts[hit]   = '0;
				ent_len[hit]  = '0;
				if (!w.found) begin
					ent_bst[hit] = BST_NO_TOOL;
				end else if (int'(w.len) > RB) begin
					ent_bst[hit] = BST_TOO_LARGE;
				end else begin
					ent_bst[hit] = BST_OK;
					ent_ts[hit]  = w.ts;
					ent_len[hit] = w.len;
				end
				r = entry_reply(hit, 1'b0);
			end
			replies_due.push_back(r);
		endfunction

		// Accepted response word: compare against the oldest owed reply.
		task check_reply(reply_word_t got);
			reply_word_t want;
			n_checked++;
			if (replies_due.size() == 0) begin
				report_mismatch("reply with nothing outstanding");
				return;
			end
			want = replies_due.pop_front();
			if (got.bst !== want.bst)
				report_mismatch($sformatf("block_status %0d, want %0d", got.bst, want.bst));
			if (got.ts !== want.ts)
				report_mismatch($sformatf("echo_tool_status %0d, want %0d", got.ts, want.ts));
			if (got.cached !== want.cached)
				report_mismatch($sformatf("from_cache %0b, want %0b", got.cached, want.cached));
			if (got.len !== want.len)
				report_mismatch($sformatf("stored_length %0d, want %0d", got.len, want.len));
			if (got.slot !== want.slot)
				report_mismatch($sformatf("entry_slot %0d, want %0d", got.slot, want.slot));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	int unsigned cycle_count;
	bit          calm;       // no idling on either side while set, bar a pending long hold-off
	bit          long_hold;  // request for one long receiver hold-off
	dedup_checker sb;

	rrdc_req_if req_ch ();
	rrdc_rsp_if rsp_ch ();

	request_replay_dedup_cache_top #(
		.CACHE_ENTRIES (CE),
		.RESULT_BYTES  (RB)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// 12-unit clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// hard stop if the block hangs
	initial begin
		wait (cycle_count >= CYCLE_CAP);
		$display("request_replay_dedup_cache_top verification failed");
		$finish;
	end

	// Response monitor: values read at the edge are the pre-edge ones, so a word
	// counts exactly when valid and ready were both high going into the edge.
	always @(posedge clk) begin
		reply_word_t got;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.bst    = blk_status_t'(rsp_ch.block_status);
			got.ts     = rsp_ch.echo_tool_status;
			got.cached = rsp_ch.from_cache;
			got.len    = rsp_ch.stored_length;
			got.slot   = rsp_ch.entry_slot;
			sb.check_reply(got);
		end
	end

	// Receiver: ready toggles in stretches, mostly short with a few long stalls.
	// One nonblocking write per edge; a pending long_hold takes effect when the
	// current stretch ends and then holds ready low while the sender keeps pushing.
	initial begin
		int left;
		bit lvl;
		left = 0;
		lvl  = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				if (long_hold) begin
					lvl       = 1'b0;
					left      = LONG_HOLD;
					long_hold = 1'b0;
				end else if (calm) begin
					lvl  = 1'b1;
					left = 1;
				end else begin
					lvl  = ($urandom_range(0, 99) < 65);
					left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
						: $urandom_range(15, 60);
				end
			end
			rsp_ch.ready <= lvl;
			left--;
		end
	end

	// Sender-side gap before the next word. Valid drops only when there is a gap,
	// so back-to-back words keep valid high with a single write per edge.
	task automatic gap();
		int n;
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			n = 0;
		else if (r < 92)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 40);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Offer one word and hold it until the handshake, then tell the checker.
	task automatic send_call(call_word_t w);
		gap();
		req_ch.valid           <= 1'b1;
		req_ch.operation       <= w.op;
		req_ch.call_id         <= w.id;
		req_ch.arg_hash        <= w.dig;
		req_ch.tool_found      <= w.found;
		req_ch.tool_status     <= w.ts;
		req_ch.produced_length <= w.len;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_call(w);
	endtask

	task automatic call(logic signed [ID_W-1:0] id, logic [DIG_W-1:0] dig, logic found,
			logic [TS_W-1:0] ts, logic [LEN_W-1:0] len);
		call_word_t w;
		w.op    = OP_CALL;
		w.id    = id;
		w.dig   = dig;
		w.found = found;
		w.ts    = ts;
		w.len   = len;
		send_call(w);
	endtask

	// Session reset; the other fields carry junk the block must ignore.
	task automatic reset_session();
		call_word_t w;
		w.op    = OP_RESET;
		w.id    = $urandom;
		w.dig   = $urandom;
		w.found = $urandom_range(0, 1);
		w.ts    = $urandom_range(0, 15);
		w.len   = $urandom;
		send_call(w);
	endtask

	// Sender stops until every owed reply has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.replies_due.size() != 0);
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return LEN_W'($urandom_range(0, RB));
		if (r < 80) return LEN_W'($urandom_range(RB + 1, 65535));
		if (r < 90) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return LEN_W'(RB);
				2: return LEN_W'(RB + 1);
				default: return '1;
			endcase
		end
		return LEN_W'($urandom);
	endfunction

	// Random word, biased toward sequences that exercise the table: fresh ids
	// climbing past the mark, replays of live slots, some conflicts and expired ids,
	// with bad ids and session resets as noise.
	task automatic random_word();
		logic [HWM_W-1:0] room;
		logic [HWM_W-1:0] step;
		int               r;
		int               s;
		logic signed [ID_W-1:0] id;
		logic [DIG_W-1:0] dig;
		bit               fresh;
		r     = $urandom_range(0, 99);
		dig   = $urandom;
		fresh = 1'b0;
		room  = 31'h7FFF_FFFF - sb.mark;
		if (r < 2) begin
			reset_session();
			return;
		end else if (r < 6) begin
			// zero or negative id
			id = ($urandom_range(0, 3) == 0) ? '0 : {1'b1, 31'($urandom)};
		end else if (r < 46) begin
			fresh = 1'b1;
		end else if (r < 86) begin
			s = $urandom_range(0, CE - 1);
			if (sb.live[s]) begin
				id  = {1'b0, sb.ent_id[s]};
				dig = sb.ent_dig[s];
				if ($urandom_range(0, 9) == 0)
					dig = dig ^ (32'h1 << $urandom_range(0, 31));
			end else begin
				fresh = 1'b1;
			end
		end else begin
			// at or below the mark, mostly evicted or never stored
			if (sb.mark != 0)
				id = {1'b0, 31'($urandom_range(1, sb.mark))};
			else
				fresh = 1'b1;
		end
		if (fresh) begin
			if (room == 0) begin
				// id space exhausted
				reset_session();
				return;
			end
			if (room <= 3 || $urandom_range(0, 99) >= 5)
				step = (room <= 3) ? 31'd1 : 31'($urandom_range(1, 3));
			else
				step = 31'($urandom_range(1, room));
			id = {1'b0, sb.mark + step};
		end
		call(id, dig, ($urandom_range(0, 9) != 0), 4'($urandom_range(0, 15)), pick_length());
	endtask

	initial begin
		sb = new();
		calm      = 1'b0;
		long_hold = 1'b0;
		cycle_count = 0;
		arst_n = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.operation       = OP_CALL;
		req_ch.call_id         = '0;
		req_ch.arg_hash        = '0;
		req_ch.tool_found      = 1'b0;
		req_ch.tool_status     = '0;
		req_ch.produced_length = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		reset_session();                                  // session reset on empty table
		call(5, 32'hFFFF_FFFF, 1'b1, 4'hF, 16'(RB));      // fresh, length at the limit
		call(5, 32'hFFFF_FFFF, 1'b1, 4'h0, 16'h0);        // replay of slot 0
		call(5, 32'h0, 1'b1, 4'h0, 16'h0);                // same id, other digest
		call(3, 32'h0, 1'b1, 4'h0, 16'h0);                // below mark, never stored
		call(0, 32'h1234_5678, 1'b1, 4'h3, 16'h10);       // id zero
		call(-1, 32'h1234_5678, 1'b1, 4'h3, 16'h10);      // negative id
		call(32'sh8000_0000, 32'h0, 1'b1, 4'h3, 16'h10);  // most negative id
		call(6, 32'hA5A5_A5A5, 1'b0, 4'h9, 16'd100);      // tool missing
		call(7, 32'h5A5A_5A5A, 1'b1, 4'h7, 16'(RB + 1));  // just too large
		call(8, 32'h0000_0001, 1'b1, 4'h7, 16'hFFFF);     // saturated length
		call(9, 32'h8000_0000, 1'b1, 4'h0, 16'h0);        // ok, all-zero outcome
		call(6, 32'hA5A5_A5A5, 1'b1, 4'h0, 16'h0);        // replay of a tool-missing entry
		call(7, 32'h5A5A_5A5A, 1'b1, 4'h0, 16'h0);        // replay of a too-large entry
		for (int i = 10; i <= 14; i++)                    // ring wraps, evicts id 5
			call(i, 32'(i), 1'b1, 4'(i), 16'(i));
		call(5, 32'hFFFF_FFFF, 1'b1, 4'h0, 16'h0);        // evicted: expired
		call(14, 32'd14, 1'b1, 4'h0, 16'h0);              // replay after wrap
		call(32'sh7FFF_FFFF, 32'hDEAD_BEEF, 1'b1, 4'hC, 16'd1);  // largest id
		call(32'sh7FFF_FFFF, 32'hDEAD_BEEF, 1'b1, 4'h0, 16'h0);
		reset_session();
		call(5, 32'h0BAD_F00D, 1'b1, 4'h2, 16'd2);        // old id is fresh after reset

		// Random part
		for (int i = 0; i < N_WORDS - 25; i++) begin
			if (i % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (i == 400 || i == 1200)
				long_hold = 1'b1;
			if (i == 800)
				drain();
			random_word();
		end

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.replies_due.size() != 0);
		repeat (TAIL) @(posedge clk);
		if (sb.errors == 0)
			$display("request_replay_dedup_cache_top verification clean");
		else
			$display("request_replay_dedup_cache_top verification failed");
		$finish;
	end
endmodule

### filelist.f
hdl/rrdc_pkg.sv
hdl/rrdc_req_if.sv
hdl/rrdc_rsp_if.sv
hdl/rrdc_ctrl.sv
hdl/rrdc_dpath.sv
hdl/request_replay_dedup_cache_top.sv
hdl/rrdc_checker.sv
sim/tb.sv
